// ===== hdl/quoted_whitespace_tokenizer_core_defines.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef QUOTED_WHITESPACE_TOKENIZER_CORE_DEFINES_SVH
`define QUOTED_WHITESPACE_TOKENIZER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on clk, idle while arst_n is low
`define QWT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked on clk, idle while arst_n is low
`define QWT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define QWT_ASSERT_IMP(label, ante, cons, msg)
`define QWT_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== hdl/qwt_pkg.sv =====
// Types and constants of the quoted whitespace tokenizer.
package qwt_pkg;

	localparam int unsigned MAX_STRING_BYTES_DEF = 65536;
	localparam logic [9:0]  MAX_TOKENS_RST       = 10'd64;

	localparam logic [7:0] CHAR_QUOTE  = 8'h22;
	localparam logic [7:0] CHAR_BSLASH = 8'h5C;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_TAB    = 8'h09;
	localparam logic [7:0] CHAR_CR     = 8'h0D;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_PLAIN,
		MODE_QUOTED
	} mode_t;

	// Scanner control state carried between bytes
	typedef struct packed {
		mode_t      mode;
		logic       esc;
		logic [9:0] found;
	} scan_ctl_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic        token_valid;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic [9:0]  token_index;
		logic        was_quoted;
		logic        string_done;
		logic [9:0]  token_count;
	} out_item_t;

endpackage

// ===== hdl/quoted_whitespace_tokenizer_core.sv =====
// Top level of the quoted whitespace tokenizer: registers, handshakes, checks.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------
//  in      | input     | in_valid/in_stall   | in_data  (in_item_t)
//  out     | output    | out_valid/out_stall | out_data (out_item_t)
//  cfg     | input     | cfg_valid/cfg_ready | cfg_data (max_tokens, 10 b)
//
// One byte per cycle sustained unless the output stalls; an accepted byte
// is held in the input register, and its result item enters the output
// register as the byte moves on. The scan state (mode, position, start,
// count) is updated once per byte by a single pass of compare/add logic.
// Reset clears the scan state and sets max_tokens to 64; cfg_ready is
// always high. in_stall rises only when a byte with a result is waiting
// while the output register holds an item that is stalled.
`include "quoted_whitespace_tokenizer_core_defines.svh"

module quoted_whitespace_tokenizer_core
	import qwt_pkg::*;
#(
	parameter int unsigned MAX_STRING_BYTES = MAX_STRING_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [9:0] cfg_data
);

	localparam int unsigned POS_W = $clog2(MAX_STRING_BYTES + 1);

	logic             valid_s1;
	in_item_t         item_s1;
	scan_ctl_t        ctl_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] start_q;
	logic [9:0]       max_tokens_q;
	logic             out_valid_q;
	out_item_t        out_q;

	scan_ctl_t        ctl_nxt;
	logic [POS_W-1:0] pos_nxt;
	logic [POS_W-1:0] start_nxt;
	logic             has_result;
	out_item_t        result;
	logic             out_free;
	logic             advance;

	qwt_step #(
		.MAX_STRING_BYTES(MAX_STRING_BYTES)
	) u_step (
		.ctl        (ctl_q),
		.pos        (pos_q),
		.start      (start_q),
		.item       (item_s1),
		.max_tokens (max_tokens_q),
		.ctl_nxt    (ctl_nxt),
		.pos_nxt    (pos_nxt),
		.start_nxt  (start_nxt),
		.has_result (has_result),
		.result     (result)
	);

	// Flow control: a byte moves on unless its result would overrun the output
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && (!has_result || out_free);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			ctl_q        <= '{mode: MODE_IDLE, esc: 1'b0, found: 10'd0};
			pos_q        <= '0;
			start_q      <= '0;
			max_tokens_q <= MAX_TOKENS_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				ctl_q   <= ctl_nxt;
				pos_q   <= pos_nxt;
				start_q <= start_nxt;
			end
			if (advance && has_result) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				max_tokens_q <= cfg_data;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (advance && has_result) begin
			out_q <= result;
		end
	end

	// Checks
	`QWT_ASSERT_IMP(a_token_count, out_valid && out_data.token_valid,
		out_data.token_count == out_data.token_index + 10'd1,
		"token count does not follow token index")
	`QWT_ASSERT_IMP(a_empty_fields, out_valid && !out_data.token_valid,
		(out_data.token_start == 16'd0) && (out_data.token_length == 16'd0) &&
		(out_data.token_index == 10'd0) && !out_data.was_quoted,
		"result without token carries nonzero token fields")
	`QWT_ASSERT_IMP(a_stall_cause, in_stall,
		valid_s1 && out_valid && out_stall,
		"input stalled while output is free")
	`QWT_ASSERT_NXT(a_string_clear, advance && item_s1.end_of_string,
		(ctl_q.mode == MODE_IDLE) && (ctl_q.found == 10'd0) && (pos_q == '0),
		"scan state not cleared after last byte")

endmodule

// ===== hdl/qwt_step.sv =====
// Per-byte scan logic: next state and result item for one input byte.
module qwt_step
	import qwt_pkg::*;
#(
	parameter int unsigned MAX_STRING_BYTES = MAX_STRING_BYTES_DEF
) (
	input  scan_ctl_t                                   ctl,
	input  logic [$clog2(MAX_STRING_BYTES + 1)-1:0]     pos,
	input  logic [$clog2(MAX_STRING_BYTES + 1)-1:0]     start,
	input  in_item_t                                    item,
	input  logic [9:0]                                  max_tokens,
	output scan_ctl_t                                   ctl_nxt,
	output logic [$clog2(MAX_STRING_BYTES + 1)-1:0]     pos_nxt,
	output logic [$clog2(MAX_STRING_BYTES + 1)-1:0]     start_nxt,
	output logic                                        has_result,
	output out_item_t                                   result
);

	localparam int unsigned POS_W = $clog2(MAX_STRING_BYTES + 1);

	logic             is_space;
	logic             is_quote;
	logic             is_bslash;
	logic             in_range;
	logic             tok_valid;
	logic             tok_quoted;
	logic [POS_W-1:0] tok_start;
	logic [POS_W-1:0] tok_len;
	logic [POS_W-1:0] len_mid;
	logic [POS_W-1:0] len_end;
	logic [9:0]       found_inc;
	logic [POS_W+15:0] start_wide;
	logic [POS_W+15:0] len_wide;
	scan_ctl_t        ctl_mid;
	logic [POS_W-1:0] pos_mid;
	logic [POS_W-1:0] start_mid;

	assign is_space  = (item.char_byte == CHAR_SPACE) ||
		((item.char_byte >= CHAR_TAB) && (item.char_byte <= CHAR_CR));
	assign is_quote  = (item.char_byte == CHAR_QUOTE);
	assign is_bslash = (item.char_byte == CHAR_BSLASH);
	assign in_range  = (pos < POS_W'(MAX_STRING_BYTES));
	assign found_inc = ctl.found + 10'd1;

	// Mode transitions for a byte inside the string window
	always_comb begin
		ctl_mid   = ctl;
		pos_mid   = pos;
		start_mid = start;
		tok_valid = 1'b0;
		tok_quoted = 1'b0;
		if (in_range) begin
			case (ctl.mode)
				MODE_IDLE: begin
					if (!is_space && (ctl.found < max_tokens)) begin
						ctl_mid.esc = 1'b0;
						if (is_quote) begin
							ctl_mid.mode = MODE_QUOTED;
							start_mid    = pos + POS_W'(1);
						end else begin
							ctl_mid.mode = MODE_PLAIN;
							start_mid    = pos;
						end
					end
				end
				MODE_PLAIN: begin
					tok_valid = is_space;
				end
				MODE_QUOTED: begin
					if (ctl.esc && (is_quote || is_bslash)) begin
						ctl_mid.esc = 1'b0;
					end else if (is_quote) begin
						ctl_mid.esc = 1'b0;
						tok_valid   = 1'b1;
						tok_quoted  = 1'b1;
					end else begin
						ctl_mid.esc = is_bslash;
					end
				end
				default: begin
					ctl_mid.mode = MODE_IDLE;
				end
			endcase
			pos_mid = pos + POS_W'(1);
		end
	end

	// Token length: at a separator or closing quote, or at end of string
	assign len_mid = pos - start;
	assign len_end = (pos_mid >= start_mid) ? (pos_mid - start_mid) : '0;

	// Token close, end-of-string flush and result assembly
	always_comb begin
		ctl_nxt   = ctl_mid;
		pos_nxt   = pos_mid;
		start_nxt = start_mid;
		tok_start = start;
		tok_len   = len_mid;
		result    = '0;
		if (!tok_valid && item.end_of_string && (ctl_mid.mode != MODE_IDLE)) begin
			tok_start = start_mid;
			tok_len   = len_end;
		end
		start_wide = {16'b0, tok_start};
		len_wide   = {16'b0, tok_len};
		if (tok_valid || (item.end_of_string && (ctl_mid.mode != MODE_IDLE))) begin
			result.token_valid  = 1'b1;
			result.token_start  = start_wide[15:0];
			result.token_length = len_wide[15:0];
			result.token_index  = ctl.found;
			result.was_quoted   = tok_valid ? tok_quoted : (ctl_mid.mode == MODE_QUOTED);
			ctl_nxt.found       = found_inc;
			ctl_nxt.mode        = MODE_IDLE;
			ctl_nxt.esc         = 1'b0;
		end
		has_result         = result.token_valid || item.end_of_string;
		result.string_done = item.end_of_string;
		result.token_count = ctl_nxt.found;
		// A finished string returns the scanner to its reset state
		if (item.end_of_string) begin
			ctl_nxt   = '{mode: MODE_IDLE, esc: 1'b0, found: 10'd0};
			pos_nxt   = '0;
			start_nxt = '0;
		end
	end

endmodule
